@@ design/m4vt_pkg.sv @@
// m4vt_pkg: shared types and constants of the 4x4 matrix-vector transform.
// No dependencies; imported by every module of the block.
`default_nettype none
package m4vt_pkg;

    localparam int LANES      = 4;   // one lane per matrix row
    localparam int COLS       = 4;   // vector components per item
    localparam int COEF_W     = 16;  // signed Q3.12 coefficient
    localparam int COMP_W     = 32;  // signed Q15.16 vector component
    localparam int PROD_W     = COEF_W + COMP_W;      // 48
    localparam int PAIR_W     = PROD_W + 1;           // 49
    localparam int SUM_W      = PROD_W + 2;           // 50
    localparam int FRAC_SHIFT = 12;
    localparam int QUOT_W     = SUM_W - FRAC_SHIFT;   // 38
    localparam int ROW_W      = COLS * COEF_W;        // 64
    localparam int VEC_W      = COLS * COMP_W;        // 128
    localparam int ADDR_W     = 5;

    typedef logic [ROW_W-1:0]         t_row;
    typedef logic [VEC_W-1:0]         t_vec;
    typedef logic signed [SUM_W-1:0]  t_lane_sum;

    // Control that travels from the top level into the merge stage
    typedef struct packed {
        logic adv;   // whole pipeline advances this cycle
        logic vld;   // last lane stage holds an item
    } t_pipe_ctl;

    // Identity matrix after reset
    localparam t_row ROW_RESET [LANES] = '{
        64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
        64'h0000_1000_0000_0000, 64'h1000_0000_0000_0000
    };

endpackage
`default_nettype wire

@@ design/matrix4_vector_transform.sv @@
// matrix4_vector_transform: 4x4 fixed-point matrix times homogeneous vector.
// Depends on m4vt_pkg, m4vt_lane and m4vt_merge.
//
//  channel  dir  handshake                 payload
//  s_*      in   s_tvalid / s_tready       s_tdata: x_in, y_in, z_in, w_in
//  m_*      out  m_tvalid / m_tready       m_tdata: x_out..w_out, m_tuser: saturated
//  apb      in   psel, penable, pwrite     4 x 64-bit row registers at 8*i
//
//  One item per cycle sustained; m_tvalid rises once an accepted item has passed the
//  product, pair sum and rounded sum registers in each lane, then the merge register.
//  All stages advance together; a result held at m_* stalls the pipeline
//  only while m_tready is low, and s_tready drops only then.
//  Reset (synchronous, active low) empties the pipeline and loads the
//  identity matrix.
`default_nettype none
module matrix4_vector_transform
    import m4vt_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input items
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [VEC_W-1:0]  s_tdata,   // x_in[31:0], y_in, z_in, w_in[127:96]
    // result items
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [VEC_W-1:0]       m_tdata,   // x_out[31:0], y_out, z_out, w_out[127:96]
    output logic                   m_tuser,   // saturated
    // register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [ROW_W-1:0]  pwdata,
    output logic [ROW_W-1:0]       prdata,
    output logic                   pready
);

    t_row        r_row [LANES];
    logic [2:0]  r_stage_vld;   // valid of lane stages 1..3
    logic [2:0]  n_stage_vld;
    logic        w_adv;
    logic [1:0]  w_reg_idx;
    t_pipe_ctl   w_ctl;
    t_lane_sum   w_sums [LANES];

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[ADDR_W-1:3];
    assign prdata    = r_row[w_reg_idx];

    // Load a row register on the APB access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < LANES; r++) begin
                r_row[r] <= ROW_RESET[r];
            end
        end else if (psel && penable && pwrite && pready) begin
            r_row[w_reg_idx] <= pwdata;
        end
    end

    // Advance everything whenever the output register is free or being taken
    assign w_adv    = !m_tvalid || m_tready;
    assign s_tready = w_adv;

    always_comb begin
        n_stage_vld = r_stage_vld;
        if (w_adv) begin
            n_stage_vld = {r_stage_vld[1:0], s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_vld <= '0;
        end else begin
            r_stage_vld <= n_stage_vld;
        end
    end

    // One lane per matrix row
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        m4vt_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_adv),
            .i_coefs (r_row[l]),
            .i_vec   (s_tdata),
            .o_sum   (w_sums[l])
        );
    end

    assign w_ctl.adv = w_adv;
    assign w_ctl.vld = r_stage_vld[2];

    // Saturate, combine flags, hold the result item
    m4vt_merge #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_sums  (w_sums),
        .o_valid (m_tvalid),
        .o_data  (m_tdata),
        .o_sat   (m_tuser)
    );

endmodule
`default_nettype wire

@@ design/m4vt_lane.sv @@
// m4vt_lane: one row lane, dot product of a coefficient row with the vector.
// Depends on m4vt_pkg. Three register stages: products, pair sums, rounded sum.
`default_nettype none
module m4vt_lane
    import m4vt_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_en,
    input  wire t_row      i_coefs,
    input  wire t_vec      i_vec,
    output t_lane_sum      o_sum
);

    logic signed [PROD_W-1:0] r_prod [COLS];
    logic signed [PAIR_W-1:0] r_pair [2];
    t_lane_sum                r_sum;
    logic signed [PROD_W-1:0] w_prod [COLS];

    // Column c: coefficient bits 16c+15..16c, component bits 32c+31..32c
    always_comb begin
        for (int c = 0; c < COLS; c++) begin
            w_prod[c] = PROD_W'($signed(i_coefs[c*COEF_W +: COEF_W]))
                      * PROD_W'($signed(i_vec[c*COMP_W +: COMP_W]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < COLS; c++) begin
                r_prod[c] <= w_prod[c];
            end
            r_pair[0] <= PAIR_W'(r_prod[0]) + PAIR_W'(r_prod[1]);
            r_pair[1] <= PAIR_W'(r_prod[2]) + PAIR_W'(r_prod[3]);
            // add half an output LSB here so the merge stage only shifts
            r_sum     <= SUM_W'(r_pair[0]) + SUM_W'(r_pair[1])
                       + (SUM_W'(1) <<< (FRAC_SHIFT - 1));
        end
    end

    assign o_sum = r_sum;

endmodule
`default_nettype wire

@@ design/m4vt_merge.sv @@
// m4vt_merge: saturate the four lane sums, combine clip flags, output register.
// Depends on m4vt_pkg.
`default_nettype none
module m4vt_merge
    import m4vt_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_pipe_ctl  i_ctl,
    input  wire t_lane_sum  i_sums [LANES],
    output logic            o_valid,
    output t_vec            o_data,
    output logic            o_sat
);

    localparam int SAT_W = (DATA_WIDTH < COMP_W) ? DATA_WIDTH : COMP_W;
    localparam logic signed [QUOT_W-1:0] SAT_HI =
        (QUOT_W'(1) <<< (SAT_W - 1)) - QUOT_W'(1);
    localparam logic signed [QUOT_W-1:0] SAT_LO = -SAT_HI - QUOT_W'(1);

    logic                     r_valid;
    t_vec                     r_data;
    logic                     r_sat;
    t_vec                     w_data;
    logic [LANES-1:0]         w_clip;
    logic signed [QUOT_W-1:0] w_quot [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_quot[l] = i_sums[l][SUM_W-1:FRAC_SHIFT];
            w_clip[l] = 1'b0;
            if (w_quot[l] > SAT_HI) begin
                w_quot[l] = SAT_HI;
                w_clip[l] = 1'b1;
            end else if (w_quot[l] < SAT_LO) begin
                w_quot[l] = SAT_LO;
                w_clip[l] = 1'b1;
            end
            w_data[l*COMP_W +: COMP_W] = w_quot[l][COMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.adv) begin
            r_valid <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_data <= w_data;
            r_sat  <= |w_clip;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_sat   = r_sat;

endmodule
`default_nettype wire

@@ design/m4vt_checker.sv @@
// m4vt_checker: port-level assertions for matrix4_vector_transform.
// Depends on m4vt_pkg; bound to the top level at the end of this file.
`default_nettype none
module m4vt_checker
    import m4vt_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_tready,
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [VEC_W-1:0]  m_tdata,
    input  wire logic              m_tuser
);

    localparam int SAT_W = (DATA_WIDTH < COMP_W) ? DATA_WIDTH : COMP_W;
    localparam logic [COMP_W-1:0] SAT_HI = COMP_W'((64'd1 << (SAT_W - 1)) - 64'd1);
    localparam logic [COMP_W-1:0] SAT_LO = ~SAT_HI;

    logic w_at_limit;

    always_comb begin
        w_at_limit = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            if (m_tdata[l*COMP_W +: COMP_W] == SAT_HI
                    || m_tdata[l*COMP_W +: COMP_W] == SAT_LO) begin
                w_at_limit = 1'b1;
            end
        end
    end

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result item shown right after reset");

    // Input side stalls only behind a stalled result
    a_ready_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

    // A clip flag needs a component at the limit
    a_sat_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser) |-> w_at_limit)
        else $error("saturated flag set with no component at a limit");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result item changed");

endmodule

bind matrix4_vector_transform m4vt_checker #(.DATA_WIDTH(DATA_WIDTH)) u_m4vt_checker (.*);
`default_nettype wire

@@ test/matrix4_vector_transform_test.sv @@
// matrix4_vector_transform_test: self-checking bench for the 4x4 matrix-vector transform.
// Depends on m4vt_pkg and matrix4_vector_transform; drives items, row registers and
// backpressure, and checks every result item against a built-in fixed-point predictor.
`timescale 1ns / 1ps
module matrix4_vector_transform_test;
    import m4vt_pkg::*;

    localparam int DUT_WIDTH   = 32;
    localparam int SAT_BITS    = (DUT_WIDTH < COMP_W) ? DUT_WIDTH : COMP_W;
    localparam int ROW_STRIDE  = 8;      // byte step between 64-bit row registers
    localparam int PIPE_LAT    = 4;      // register stages from accept to m_tdata
    localparam int IDLE_PCT    = 10;     // idle cycles per hundred on either side
    localparam int PHASE_ITEMS = 200;
    localparam int RAND_PHASES = 8;
    localparam int CALM_PHASE  = 2;      // no idling on either side in this phase
    localparam int HOLD_AT     = 24 + 4 * PHASE_ITEMS + 50;
    localparam int HOLD_CYC    = 300;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        t_vec data;
        logic clip;
    } t_xform_result;

    // Prediction of the transform plus the queue of results still owed by the block
    class m4vt_scoreboard;
        t_row          rows[LANES];
        t_xform_result owed[$];
        int            n_in;
        int            n_err;

        function new();
            for (int r = 0; r < LANES; r++) rows[r] = ROW_RESET[r];
            n_in  = 0;
            n_err = 0;
        endfunction

        // Work out the four rounded, saturated dot products of an accepted vector
        function void note_vector(t_vec v);
            t_xform_result    res;
            logic signed [COEF_W-1:0] coef;
            logic signed [COMP_W-1:0] comp;
            longint           acc;
            longint           q;
            longint           hi;
            longint           lo;
            hi       = (64'sd1 <<< (SAT_BITS - 1)) - 1;
            lo       = -hi - 1;
            res.clip = 1'b0;
            res.data = '0;
            for (int r = 0; r < LANES; r++) begin
                acc = 0;
                for (int c = 0; c < COLS; c++) begin
                    coef = rows[r][COEF_W*c +: COEF_W];
                    comp = v[COMP_W*c +: COMP_W];
                    acc += longint'(coef) * longint'(comp);
                end
                // add half an LSB, then floor: ties go toward plus infinity
                q = (acc + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
                if (q > hi) begin
                    q        = hi;
                    res.clip = 1'b1;
                end else if (q < lo) begin
                    q        = lo;
                    res.clip = 1'b1;
                end
                res.data[COMP_W*r +: COMP_W] = q[COMP_W-1:0];
            end
            owed.push_back(res);
            n_in++;
        endfunction

        function void check_result(t_vec data, logic clip);
            t_xform_result exp_res;
            string         lane_name[LANES] = '{"x_out", "y_out", "z_out", "w_out"};
            if (owed.size() == 0) begin
                $error("result item with no expectation: tdata %h tuser %b", data, clip);
                n_err++;
                return;
            end
            exp_res = owed.pop_front();
            for (int r = 0; r < LANES; r++) begin
                if (data[COMP_W*r +: COMP_W] !== exp_res.data[COMP_W*r +: COMP_W]) begin
                    $error("%s mismatch: expected %h, got %h", lane_name[r],
                           exp_res.data[COMP_W*r +: COMP_W], data[COMP_W*r +: COMP_W]);
                    n_err++;
                end
            end
            if (clip !== exp_res.clip) begin
                $error("saturated mismatch: expected %b, got %b", exp_res.clip, clip);
                n_err++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [VEC_W-1:0]  s_tdata  = '0;   // x_in[31:0], y_in, z_in, w_in[127:96]
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [VEC_W-1:0]  m_tdata;         // x_out[31:0], y_out, z_out, w_out[127:96]
    logic              m_tuser;         // saturated
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [ROW_W-1:0]  pwdata   = '0;
    logic [ROW_W-1:0]  prdata;
    logic              pready;

    m4vt_scoreboard xform_sb = new();
    logic           calm     = 1'b0;    // both sides stop idling while set
    int             cycle_count = 0;

    matrix4_vector_transform #(
        .DATA_WIDTH(DUT_WIDTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here
    initial begin
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: check each accepted result, then pick the next tready.
    // Once the input count reaches HOLD_AT, hold tready low, once, until a countdown from
    // HOLD_CYC runs out, so the pipeline fills and s_tready drops while the sender keeps offering.
    initial begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (m_tvalid && m_tready) begin
                xform_sb.check_result(m_tdata, m_tuser);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!held && xform_sb.n_in >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYC;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // APB write: setup cycle, access cycle, done at the edge that sees pready
    task automatic write_row(input int idx, input t_row value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * ROW_STRIDE);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        xform_sb.rows[idx] = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_matrix(input t_row m0, input t_row m1, input t_row m2, input t_row m3);
        write_row(0, m0);
        write_row(1, m1);
        write_row(2, m2);
        write_row(3, m3);
    endtask

    // Offer one item and hold it until accepted; maybe idle afterwards
    task automatic send_vector(input t_vec v);
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge i_clk); while (!s_tready);
        xform_sb.note_vector(v);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Drop valid and let every owed result drain before touching registers
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (xform_sb.pending() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return '0;
            3, 4:    return COEF_W'($urandom_range(8192) - 4096);
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic logic [COMP_W-1:0] pick_comp();
        case ($urandom_range(7))
            0:          return 32'h7FFF_FFFF;
            1:          return 32'h8000_0000;
            2:          return '0;
            3, 4, 5:    return COMP_W'($urandom_range(2097152) - 1048576);
            default:    return $urandom;
        endcase
    endfunction

    function automatic t_row pick_row();
        return {pick_coef(), pick_coef(), pick_coef(), pick_coef()};
    endfunction

    // Main sequence: reset, directed vectors under three matrices, random phases
    initial begin
        t_vec corner[8];
        // {w, z, y, x}
        corner[0] = '0;
        corner[1] = {4{32'h7FFF_FFFF}};
        corner[2] = {4{32'h8000_0000}};
        corner[3] = {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        corner[4] = {-32'sd2049, 32'sd2049, -32'sd2048, 32'sd2048};   // rounding ties
        corner[5] = {-32'sd2047, 32'sd2047, -32'sd1, 32'sd1};
        corner[6] = {32'd0, 32'h0003_0000, 32'h0002_0000, 32'h0001_0000}; // direction, w = 0
        corner[7] = {32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_0000};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity matrix straight out of reset
        foreach (corner[k]) send_vector(corner[k]);
        drain();

        // one LSB on the diagonal: exposes half-LSB rounding in both signs
        load_matrix(64'h0000_0000_0000_0001, 64'h0000_0000_0001_0000,
                    64'h0000_0001_0000_0000, 64'h0001_0000_0000_0000);
        foreach (corner[k]) send_vector(corner[k]);
        drain();

        // extreme coefficients: drives every lane into saturation, x_out and y_out into both limits
        load_matrix({4{16'h7FFF}}, {4{16'h8000}},
                    {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
                    {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
        foreach (corner[k]) send_vector(corner[k]);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 0) begin
                load_matrix('0, '0, '0, '0);
            end else begin
                load_matrix(pick_row(), pick_row(), pick_row(), pick_row());
            end
            calm = (ph == CALM_PHASE);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_vector({pick_comp(), pick_comp(), pick_comp(), pick_comp()});
            end
            drain();
            calm = 1'b0;
        end

        repeat (PIPE_LAT * 4) @(posedge i_clk);
        if (xform_sb.n_err == 0 && xform_sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/m4vt_pkg.sv
design/m4vt_lane.sv
design/m4vt_merge.sv
design/matrix4_vector_transform.sv
design/m4vt_checker.sv
test/matrix4_vector_transform_test.sv
